// ===== rtl/core/fde_pkg.sv =====
// shared constants for the feedback delay echo core
package fde_pkg;

   // configuration field widths
   localparam int DELAY_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int MIX_W      = 16;
   localparam int CHCNT_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FRAMES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_GAIN      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd3;

   // q1.15 constants
   localparam int              Q15_W     = 17;
   localparam logic [Q15_W-1:0] Q15_ONE  = 17'd32768;
   localparam int              Q15_HALF  = 16384;
   localparam int              Q15_SHIFT = 15;
   // gain operand width at the multiplier, one bit over q15 unsigned one
   localparam int              GAIN_EXT_W = 18;

endpackage

// ===== rtl/core/fde_position.sv =====
// ring slot, channel and frame counters that form the delay memory addresses
module fde_position #(
   parameter int MAX_DELAY_FRAMES = 16384,
   parameter int MAX_CHANNELS     = 2,
   localparam int RP_W = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1,
   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
   localparam int AW   = RP_W + CH_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         buffer_start,
   input  logic [fde_pkg::DELAY_W-1:0]  delay_frames,
   input  logic [fde_pkg::CHCNT_W-1:0]  channel_count,
   output logic [AW-1:0]                rd_addr,
   output logic [AW-1:0]                wr_addr,
   output logic                         use_delay
);
   import fde_pkg::*;

   localparam int FS_W  = $clog2(MAX_DELAY_FRAMES + 1);
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam logic [31:0] MAX_D = 32'(MAX_DELAY_FRAMES);

   logic [RP_W-1:0]  ring_ff, ring_in;
   logic [CH_W-1:0]  chan_ff, chan_in;
   logic [FS_W-1:0]  frames_ff, frames_in;

   logic [CH_W-1:0]  chan_cur, ch;
   logic [FS_W-1:0]  frames_cur, dly;
   logic [CNT_W-1:0] chans;
   logic [31:0]      dly_w, slot_sum, slot_w;
   logic [RP_W-1:0]  rd_slot;
   logic             last_chan;

   // buffer start restarts channel and frame count but keeps the ring slot
   always_comb begin
      chan_cur   = buffer_start ? '0 : chan_ff;
      frames_cur = buffer_start ? '0 : frames_ff;
   end

   // effective channel count, clamped to one and to the channel limit
   always_comb begin
      if (channel_count == '0) begin
         chans = CNT_W'(1);
      end else if (32'(channel_count) > 32'(MAX_CHANNELS)) begin
         chans = CNT_W'(MAX_CHANNELS);
      end else begin
         chans = CNT_W'(channel_count);
      end
   end

   // a stale channel index after a count change falls back to channel 0
   assign ch = (32'(chan_cur) < 32'(chans)) ? chan_cur : '0;

   // delay clamp and read slot behind the write slot
   always_comb begin
      dly_w    = (32'(delay_frames) > MAX_D) ? MAX_D : 32'(delay_frames);
      dly      = FS_W'(dly_w);
      slot_sum = 32'(ring_ff) + MAX_D - dly_w;
      slot_w   = (slot_sum >= MAX_D) ? slot_sum - MAX_D : slot_sum;
      rd_slot  = RP_W'(slot_w);
   end

   assign use_delay = (dly != '0) && (frames_cur >= dly);
   assign rd_addr   = {rd_slot, ch};
   assign wr_addr   = {ring_ff, ch};
   assign last_chan = (32'(ch) + 32'd1) >= 32'(chans);

   // counter update on each accepted transaction
   always_comb begin
      ring_in   = ring_ff;
      chan_in   = chan_ff;
      frames_in = frames_ff;
      if (advance) begin
         frames_in = frames_cur;
         if (last_chan) begin
            chan_in = '0;
            ring_in = ((32'(ring_ff) + 32'd1) == MAX_D) ? '0 : ring_ff + RP_W'(1);
            if (32'(frames_cur) < MAX_D) begin
               frames_in = frames_cur + FS_W'(1);
            end
         end else begin
            chan_in = ch + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff   <= '0;
         chan_ff   <= '0;
         frames_ff <= '0;
      end else begin
         ring_ff   <= ring_in;
         chan_ff   <= chan_in;
         frames_ff <= frames_in;
      end
   end

endmodule

// ===== rtl/core/feedback_delay_echo_core.sv =====
// feedback comb echo with dry/wet mix over a per-channel delay memory
// each sample runs feedback, echo, mix and output steps, plus any wait on rsp_tready
// samples pass one at a time through the step sequence around the shared
//   multiplier (feedback product, echo write-back, wet product, output mix)
// a waiting result admits one more sample, which then holds the input in its output step
// reset clears control, counters and config; the delay memory is not cleared
module feedback_delay_echo_core #(
   parameter int MAX_DELAY_FRAMES = 16384,
   parameter int MAX_CHANNELS     = 2,
   parameter int SAMPLE_BITS      = 16,
   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // input samples
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [DATA_W-1:0]                req_tdata,   // sample
   input  logic [1:0]                       req_tuser,   // buffer_start, tail
   // output samples
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DATA_W-1:0]                rsp_tdata,   // sample_out
   output logic [0:0]                       rsp_tuser,   // clipped
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fde_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fde_pkg::CSR_DATA_W-1:0]   csr_data
);
   import fde_pkg::*;

   localparam int RP_W  = (MAX_DELAY_FRAMES > 1) ? $clog2(MAX_DELAY_FRAMES) : 1;
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int AW    = RP_W + CH_W;
   localparam int SB    = SAMPLE_BITS;
   localparam int MUL_W = SB + GAIN_EXT_W;
   localparam int P_W   = SB + GAIN_EXT_W + 1;
   localparam logic signed [P_W-1:0] S_MAX =
      $signed(P_W'((longint'(1) <<< (SB - 1)) - 1));
   localparam logic signed [P_W-1:0] S_MIN = -S_MAX - P_W'(1);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FB   = 3'd1;
   localparam logic [2:0] ST_ECHO = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // round to nearest, ties up, dropping the q15 fraction
   function automatic logic signed [P_W-1:0] q15_round(input logic signed [P_W-1:0] p);
      return (p + $signed(P_W'(Q15_HALF))) >>> Q15_SHIFT;
   endfunction

   // saturate to the sample range, clip flag in the top bit
   function automatic logic [SB:0] sat_clip(input logic signed [P_W-1:0] v);
      logic [SB:0] r;
      if (v > S_MAX) begin
         r = {1'b1, S_MAX[SB-1:0]};
      end else if (v < S_MIN) begin
         r = {1'b1, S_MIN[SB-1:0]};
      end else begin
         r = {1'b0, v[SB-1:0]};
      end
      return r;
   endfunction

   // configuration registers
   logic [DELAY_W-1:0]        cfg_delay_ff;
   logic signed [GAIN_W-1:0]  cfg_fb_ff;
   logic [MIX_W-1:0]          cfg_mix_ff;
   logic [CHCNT_W-1:0]        cfg_chcnt_ff;

   // sequencer and datapath registers
   logic [2:0]                state_ff, state_in;
   logic signed [SB-1:0]      dry_ff;
   logic                      use_ff;
   logic [AW-1:0]             wr_addr_ff;
   logic signed [SB-1:0]      rd_data_ff;
   logic signed [P_W-1:0]     acc_ff;
   logic signed [P_W-1:0]     prod_ff;
   logic signed [SB-1:0]      echo_ff;
   logic                      clip_ff;
   logic                      rsp_valid_ff;
   logic [SB-1:0]             rsp_sample_ff;
   logic                      rsp_clip_ff;

   logic [SB-1:0]             delay_mem [2**AW];

   logic                      accept, out_free;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic                      use_delay;
   logic signed [SB-1:0]      dry_in;
   logic [Q15_W-1:0]          mix_c, inv_mix;
   logic signed [MUL_W-1:0]   dry_prod;
   logic signed [GAIN_EXT_W-1:0] mul_a;
   logic signed [SB-1:0]      mul_b;
   logic signed [MUL_W-1:0]   mul_res;
   logic [SB:0]               echo_sat, out_sat;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_delay_ff <= '0;
         cfg_fb_ff    <= '0;
         cfg_mix_ff   <= '0;
         cfg_chcnt_ff <= CHCNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELAY_FRAMES:  cfg_delay_ff <= csr_data[DELAY_W-1:0];
            CSR_FEEDBACK_GAIN: cfg_fb_ff    <= $signed(csr_data[GAIN_W-1:0]);
            CSR_MIX_GAIN:      cfg_mix_ff   <= csr_data[MIX_W-1:0];
            CSR_CHANNEL_COUNT: cfg_chcnt_ff <= csr_data[CHCNT_W-1:0];
            default:           cfg_delay_ff <= cfg_delay_ff;
         endcase
      end
   end

   // handshake: a new sample enters while idle or as the previous one finishes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_OUT) && out_free);
   assign accept     = req_tvalid && req_tready;

   fde_position #(
      .MAX_DELAY_FRAMES (MAX_DELAY_FRAMES),
      .MAX_CHANNELS     (MAX_CHANNELS)
   ) u_position (
      .clock         (clock),
      .reset         (reset),
      .advance       (accept),
      .buffer_start  (req_tuser[0]),
      .delay_frames  (cfg_delay_ff),
      .channel_count (cfg_chcnt_ff),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .use_delay     (use_delay)
   );

   // dry term and its (1 - mix) share, formed at accept
   always_comb begin
      dry_in   = req_tuser[1] ? '0 : $signed(req_tdata[SB-1:0]);
      mix_c    = (32'(cfg_mix_ff) > 32'(Q15_ONE)) ? Q15_ONE : Q15_W'(cfg_mix_ff);
      inv_mix  = Q15_ONE - mix_c;
      dry_prod = $signed({1'b0, inv_mix}) * dry_in;
   end

   // shared multiplier: feedback product, then wet product
   always_comb begin
      if (state_ff == ST_MIX) begin
         mul_a = $signed({1'b0, mix_c});
         mul_b = echo_ff;
      end else begin
         mul_a = GAIN_EXT_W'(cfg_fb_ff);
         mul_b = use_ff ? rd_data_ff : '0;
      end
      mul_res = mul_a * mul_b;
   end

   assign echo_sat = sat_clip(P_W'(dry_ff) + q15_round(prod_ff));
   assign out_sat  = sat_clip(q15_round(acc_ff + prod_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_FB;
         ST_FB:   state_in = ST_ECHO;
         ST_ECHO: state_in = ST_MIX;
         ST_MIX:  state_in = ST_OUT;
         ST_OUT: begin
            if (accept) begin
               state_in = ST_FB;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // delay memory: read every cycle, data used right after accept;
   // the echo write-back lands before the next sample can read
   always_ff @(posedge clock) begin
      rd_data_ff <= $signed(delay_mem[rd_addr]);
      if (state_ff == ST_ECHO) begin
         delay_mem[wr_addr_ff] <= echo_sat[SB-1:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         dry_ff     <= dry_in;
         use_ff     <= use_delay;
         wr_addr_ff <= wr_addr;
         acc_ff     <= P_W'(dry_prod);
      end
      if ((state_ff == ST_FB) || (state_ff == ST_MIX)) begin
         prod_ff <= P_W'(mul_res);
      end
      if (state_ff == ST_ECHO) begin
         echo_ff <= $signed(echo_sat[SB-1:0]);
         clip_ff <= echo_sat[SB];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_sample_ff <= out_sat[SB-1:0];
         rsp_clip_ff   <= out_sat[SB] | clip_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = DATA_W'(rsp_sample_ff);
   assign rsp_tuser[0] = rsp_clip_ff;

   // an accepted transaction always starts the feedback step
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FB)
      else $error("accepted sample did not enter feedback step");

   // a new result appears only out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output step");

   // a finished sample waits only while the output register is held
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !out_free |=> (state_ff == ST_OUT) && rsp_valid_ff)
      else $error("finished sample dropped while output stalled");

endmodule
